### rtl/core/bsh_pkg.sv
// ---------------------------------------------------------------------------
// bsh_pkg
// Shared constants and types for the bitset signature hash block.
// ---------------------------------------------------------------------------
package bsh_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    // Finalizer multipliers and the golden-ratio constant of the combine step.
    localparam logic [WORD_W-1:0] FMIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam logic [WORD_W-1:0] GOLDEN  = 64'h9e3779b97f4a7c15;

    localparam int unsigned FMIX_SHIFT  = 33;
    localparam int unsigned COMBINE_SHL = 6;
    localparam int unsigned COMBINE_SHR = 2;

    // Depth of the queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Sideband flags of a request as it travels through the front.
    typedef struct packed {
        logic last_word;
        logic no_word;
    } item_flags_t;

    // One queued request: the mixed word and its flags.
    typedef struct packed {
        logic [WORD_W-1:0] mixed;
        item_flags_t       flags;
    } queue_item_t;

endpackage

### rtl/core/bsh_fmix.sv
// ---------------------------------------------------------------------------
// bsh_fmix
// Three-stage pipelined 64-bit finalizer with a stallable valid/ready flow.
// ---------------------------------------------------------------------------
module bsh_fmix
    import bsh_pkg::*;
#(
    parameter int unsigned TAG_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] in_value,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_value,
    output logic [TAG_W-1:0]  out_tag
);

    logic              adv;
    logic [2:0]        valid_reg;
    logic [TAG_W-1:0]  tag1_reg, tag2_reg, tag3_reg;

    // Partial products of each 64-bit multiply, low 64 bits only.
    logic [WORD_W-1:0] pa_lo_reg, pb_lo_reg;
    logic [HALF_W-1:0] pa_x1_reg, pa_x2_reg, pb_x1_reg, pb_x2_reg;
    logic [WORD_W-1:0] out_reg;

    logic [WORD_W-1:0] x1, m1, x2, m2;
    logic [HALF_W-1:0] pa_x1_next, pa_x2_next, pb_x1_next, pb_x2_next;
    logic [WORD_W-1:0] pa_lo_next, pb_lo_next;

    assign adv      = !valid_reg[2] || out_ready;
    assign in_ready = adv;

    always_comb begin
        x1         = in_value ^ (in_value >> FMIX_SHIFT);
        pa_lo_next = x1[HALF_W-1:0] * FMIX_C1[HALF_W-1:0];
        pa_x1_next = x1[WORD_W-1:HALF_W] * FMIX_C1[HALF_W-1:0];
        pa_x2_next = x1[HALF_W-1:0] * FMIX_C1[WORD_W-1:HALF_W];

        m1         = pa_lo_reg + {pa_x1_reg + pa_x2_reg, {HALF_W{1'b0}}};
        x2         = m1 ^ (m1 >> FMIX_SHIFT);
        pb_lo_next = x2[HALF_W-1:0] * FMIX_C2[HALF_W-1:0];
        pb_x1_next = x2[WORD_W-1:HALF_W] * FMIX_C2[HALF_W-1:0];
        pb_x2_next = x2[HALF_W-1:0] * FMIX_C2[WORD_W-1:HALF_W];

        m2         = pb_lo_reg + {pb_x1_reg + pb_x2_reg, {HALF_W{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_lo_reg <= pa_lo_next;
            pa_x1_reg <= pa_x1_next;
            pa_x2_reg <= pa_x2_next;
            tag1_reg  <= in_tag;
            pb_lo_reg <= pb_lo_next;
            pb_x1_reg <= pb_x1_next;
            pb_x2_reg <= pb_x2_next;
            tag2_reg  <= tag1_reg;
            out_reg   <= m2 ^ (m2 >> FMIX_SHIFT);
            tag3_reg  <= tag2_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_value = out_reg;
    assign out_tag   = tag3_reg;

endmodule

### rtl/core/bsh_front.sv
// ---------------------------------------------------------------------------
// bsh_front
// Accepts requests, drops idle ones and mixes each word through the finalizer.
// ---------------------------------------------------------------------------
module bsh_front
    import bsh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] in_word,
    input  item_flags_t       in_flags,
    output logic              out_valid,
    input  logic              out_ready,
    output queue_item_t       out_item
);

    localparam int unsigned FLAGS_W = $bits(item_flags_t);

    logic             keep;
    logic [FLAGS_W-1:0] tag_out;

    // A request without a word that does not close a sequence changes nothing.
    assign keep = in_flags.last_word || !in_flags.no_word;

    bsh_fmix #(
        .TAG_W (FLAGS_W)
    ) u_fmix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid && keep),
        .in_ready  (in_ready),
        .in_value  (in_word),
        .in_tag    (in_flags),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_value (out_item.mixed),
        .out_tag   (tag_out)
    );

    assign out_item.flags = item_flags_t'(tag_out);

endmodule

### rtl/core/bsh_queue.sv
// ---------------------------------------------------------------------------
// bsh_queue
// Small register queue that decouples the front from the back.
// ---------------------------------------------------------------------------
module bsh_queue
    import bsh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_valid,
    output logic        wr_ready,
    input  queue_item_t wr_item,
    output logic        rd_valid,
    input  logic        rd_ready,
    output queue_item_t rd_item
);

    queue_item_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push, pop;

    assign wr_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### rtl/core/bsh_back.sv
// ---------------------------------------------------------------------------
// bsh_back
// Folds mixed words into the running hash and finalizes closed sequences.
// ---------------------------------------------------------------------------
module bsh_back
    import bsh_pkg::*;
#(
    parameter int unsigned MAX_WORDS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [WORD_W-1:0] seed,
    input  logic              in_valid,
    output logic              in_ready,
    input  queue_item_t       in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_hash,
    output logic              out_too_long
);

    localparam int unsigned CNT_W = $clog2(MAX_WORDS + 1);

    logic [WORD_W-1:0] running_hash_reg, running_hash_next;
    logic [CNT_W-1:0]  word_count_reg, word_count_next;
    logic              overflowed_reg, overflowed_next;

    logic              fin_ready, pop;
    logic [WORD_W-1:0] h_cur, h_new;
    logic [CNT_W-1:0]  cnt_new;
    logic              ovf_new;

    // The closing value is registered before the finalizer so that the
    // combine adders and the first finalizer multiply sit in separate cycles.
    logic              stage_ready;
    logic              fin_valid_reg;
    logic [WORD_W-1:0] fin_value_reg;
    logic              fin_tag_reg;

    assign stage_ready = !fin_valid_reg || fin_ready;
    assign in_ready    = stage_ready;
    assign pop         = in_valid && stage_ready;

    always_comb begin
        // A fresh sequence starts from the seed.
        h_cur   = (word_count_reg == '0) ? seed : running_hash_reg;
        h_new   = h_cur;
        cnt_new = word_count_reg;
        ovf_new = overflowed_reg;
        if (!in_item.flags.no_word) begin
            h_new = h_cur ^ (in_item.mixed + GOLDEN + (h_cur << COMBINE_SHL)
                             + (h_cur >> COMBINE_SHR));
            if (word_count_reg >= CNT_W'(MAX_WORDS)) begin
                ovf_new = 1'b1;
            end else begin
                cnt_new = word_count_reg + 1'b1;
            end
        end

        running_hash_next = running_hash_reg;
        word_count_next   = word_count_reg;
        overflowed_next   = overflowed_reg;
        if (pop) begin
            if (in_item.flags.last_word) begin
                running_hash_next = seed;
                word_count_next   = '0;
                overflowed_next   = 1'b0;
            end else begin
                running_hash_next = h_new;
                word_count_next   = cnt_new;
                overflowed_next   = ovf_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_count_reg <= '0;
            overflowed_reg <= 1'b0;
        end else begin
            word_count_reg <= word_count_next;
            overflowed_reg <= overflowed_next;
        end
    end

    always_ff @(posedge aclk) begin
        running_hash_reg <= running_hash_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (stage_ready) begin
            fin_valid_reg <= in_valid && in_item.flags.last_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready) begin
            fin_value_reg <= h_new ^ WORD_W'(cnt_new);
            fin_tag_reg   <= ovf_new;
        end
    end

    bsh_fmix #(
        .TAG_W (1)
    ) u_fmix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fin_valid_reg),
        .in_ready  (fin_ready),
        .in_value  (fin_value_reg),
        .in_tag    (fin_tag_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_value (out_hash),
        .out_tag   (out_too_long)
    );

endmodule

### rtl/core/bitset_signature_hash.sv
// ---------------------------------------------------------------------------
// bitset_signature_hash
// Running signature hash over sequences of 64-bit bitset words.
// ---------------------------------------------------------------------------
// Each request on the s_ stream carries one bitset word in s_tdata, the end of
// a sequence in s_tlast, and in s_tuser a flag that says the request carries no
// word. A request with that flag and s_tlast closes a sequence without adding a
// word; one with the flag alone is accepted and dropped. Each word is mixed by
// the finalizer and folded into a running hash that starts from the seed
// register (cfg_we/cfg_wdata, written by the user only while the block is
// idle, which the block does not enforce). The request marked last yields one
// result on the m_ stream: the final hash in m_tdata and the too-long flag in
// m_tuser. The block takes one request per cycle while m_tready does not hold
// it back. A closing request passes the three finalizer stages in the front,
// the queue, the combine-step register and the three finalizer stages in the
// back on its way to m_. The back folds a word into the running hash on every
// request it takes, so it keeps up with that rate.
// Reset clears the seed to zero, empties all pipelines and the queue, and
// rearms the word count. When m_tready is low the back pipeline holds, the
// queue fills, and s_tready falls once the front pipeline can no longer move.
// ---------------------------------------------------------------------------
module bitset_signature_hash
    import bsh_pkg::*;
#(
    parameter int unsigned MAX_WORDS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,     // hash_seed
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // bitset_word
    input  logic        s_tlast,       // last_word
    input  logic        s_tuser,       // no_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // hash_value
    output logic        m_tuser        // too_long
);

    logic [WORD_W-1:0] seed_reg;

    logic        fq_valid, fq_ready;
    queue_item_t fq_item;
    logic        qb_valid, qb_ready;
    queue_item_t qb_item;
    item_flags_t s_flags;

    // The seed register is picked up by the back at the start of a sequence.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_we) begin
            seed_reg <= cfg_wdata;
        end
    end

    assign s_flags.last_word = s_tlast;
    assign s_flags.no_word   = s_tuser;

    bsh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata),
        .in_flags  (s_flags),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_item  (fq_item)
    );

    bsh_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    bsh_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .seed         (seed_reg),
        .in_valid     (qb_valid),
        .in_ready     (qb_ready),
        .in_item      (qb_item),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_hash     (m_tdata),
        .out_too_long (m_tuser)
    );

endmodule

### tb/bitset_signature_hash_checker.sv
// ---------------------------------------------------------------------------
// bitset_signature_hash_checker
// Watches both streams of the signature hash block and checks every result.
// ---------------------------------------------------------------------------
// The checker keeps its own copy of the seed, running hash, word count and
// overflow flag. It updates them on every accepted request, queues the
// expected signature for each closing request, and compares each accepted
// result with the oldest queued signature.
// ---------------------------------------------------------------------------
module bitset_signature_hash_checker
    import bsh_pkg::*;
#(
    parameter int unsigned MAX_WORDS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] hash_value;
        logic        too_long;
    } signature_t;

    signature_t  signature_q[$];

    logic [63:0] seed_reg;
    logic [63:0] running_hash;
    int unsigned word_count;
    logic        overflowed;

    function automatic logic [63:0] fmix64(input logic [63:0] v);
        v = v ^ (v >> FMIX_SHIFT);
        v = v * FMIX_C1;
        v = v ^ (v >> FMIX_SHIFT);
        v = v * FMIX_C2;
        v = v ^ (v >> FMIX_SHIFT);
        return v;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin : predict_and_compare
        logic [63:0] h;
        signature_t  want;
        int          errors;
        errors = 0;
        if (!aresetn) begin
            seed_reg     = '0;
            running_hash = '0;
            word_count   = 0;
            overflowed   = 1'b0;
            signature_q.delete();
        end else begin
            if (cfg_we) begin
                seed_reg = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                // The seed is picked up only when a sequence starts.
                h = (word_count == 0) ? seed_reg : running_hash;
                if (!s_tuser) begin
                    h = h ^ (fmix64(s_tdata) + GOLDEN + (h << COMBINE_SHL)
                             + (h >> COMBINE_SHR));
                    if (word_count >= MAX_WORDS) begin
                        overflowed = 1'b1;
                    end else begin
                        word_count++;
                    end
                    running_hash = h;
                end
                if (s_tlast) begin
                    want.hash_value = fmix64(h ^ 64'(word_count));
                    want.too_long   = overflowed;
                    signature_q.push_back(want);
                    running_hash = seed_reg;
                    word_count   = 0;
                    overflowed   = 1'b0;
                end
            end
            if (m_tvalid && m_tready) begin
                if (signature_q.size() == 0) begin
                    $error("unexpected result: hash_value %h too_long %b",
                           m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = signature_q.pop_front();
                    if (m_tdata !== want.hash_value) begin
                        $error("hash_value: expected %h, got %h",
                               want.hash_value, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.too_long) begin
                        $error("too_long: expected %b, got %b",
                               want.too_long, m_tuser);
                        errors++;
                    end
                end
            end
        end
        fail_count <= fail_count + errors;
        pending    <= signature_q.size();
    end

endmodule

### tb/bitset_signature_hash_tb.sv
// ---------------------------------------------------------------------------
// bitset_signature_hash_tb
// Stimulus and verdict for the bitset signature hash block.
// ---------------------------------------------------------------------------
// A short directed part covers the extreme words, empty sequences, idle
// requests and closing on a word-free request. Random phases under several
// seeds then send well-formed sequences of random length, including runs at
// and past the maximum word count, mixed with stray idle requests. Both the
// sender and the receiver stall at random, with calm stretches in between.
// The checker module does all prediction and comparison.
// ---------------------------------------------------------------------------
module bitset_signature_hash_tb;
    import bsh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_WORDS     = 64;
    // Covers the trip from a closing request to its result, plus some margin
    // for requests that yield nothing but are still in flight.
    localparam int          SETTLE_CYCLES = 24;
    localparam int          PHASE_ITEMS   = 200;
    // The slowest correct run is roughly every request behind the longest gap
    // and every result behind the longest stall; this is several times that.
    localparam int          CYCLE_LIMIT   = 400_000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [63:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;      // bitset_word
    logic        s_tlast;      // last_word
    logic        s_tuser;      // no_word
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;      // hash_value
    logic        m_tuser;      // too_long

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          sent_items  = 0;
    int          rx_stall    = 0;
    int          rx_draw;

    always #1 aclk = ~aclk;

    bitset_signature_hash #(
        .MAX_WORDS (MAX_WORDS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    bitset_signature_hash_checker #(
        .MAX_WORDS (MAX_WORDS)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bitset_signature_hash: mismatch");
            $finish;
        end
    end

    // Receiver. After each accepted result it draws a random stall, except
    // during calm windows that take one quarter of the run, where it keeps
    // m_tready high so results can stream back to back.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else if (m_tvalid && m_tready) begin
            rx_draw = ((cycle_count / 256) % 4 == 0) ? 0 : $urandom_range(0, 13);
            rx_stall <= rx_draw;
            m_tready <= (rx_draw == 0);
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= (rx_stall == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Mostly random words, with the all-zero and all-one patterns mixed in.
    function automatic logic [63:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return '1;
        end
        return {$urandom(), $urandom()};
    endfunction

    // Offers one request and returns at the edge where it is accepted. The
    // sender waits a random gap before each request, except for one
    // stretch of 48 requests out of every 144, which go out without gaps.
    // tvalid is only lowered when a gap is actually inserted, so it never
    // gets two assignments in one time step.
    task automatic offer_request(input logic [63:0] word, input logic last,
                                 input logic no_word);
        int gap;
        gap = ((sent_items / 48) % 3 == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        s_tuser  <= no_word;
        do @(posedge aclk); while (!s_tready);
        // Idle requests are simply dropped by the block and are not counted.
        if (last || !no_word) begin
            sent_items++;
        end
    endtask

    // Holds the sender until every expected signature has come back, then
    // lets the pipeline run dry. The first edge makes sure a request taken
    // at the previous edge is already counted by the checker.
    task automatic wait_for_signatures();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Seed writes happen only while the block is idle.
    task automatic load_seed(input logic [63:0] seed);
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One sequence of len words with random content. A zero-length sequence
    // is closed by a word-free request with tlast. A longer one is closed
    // either on its final word or by a trailing word-free request with
    // tlast. Stray idle requests are sprinkled in between words.
    task automatic send_sequence(input int len);
        bit close_apart;
        close_apart = (len == 0) || ($urandom_range(0, 9) < 3);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                offer_request(pick_word(), 1'b0, 1'b1);
            end
            offer_request(pick_word(), !close_apart && (i == len - 1), 1'b0);
        end
        if (close_apart) begin
            offer_request(pick_word(), 1'b1, 1'b1);
        end
    endtask

    initial begin : stimulus
        logic [63:0] phase_seed [4];
        int          phase_start;
        int          pick;

        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        s_tuser   <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset seed of zero: an empty sequence,
        // single extreme words, an idle request on its own, an idle request
        // inside a sequence, and a sequence closed by a word-free request.
        offer_request('0, 1'b1, 1'b1);
        offer_request('0, 1'b1, 1'b0);
        offer_request('1, 1'b1, 1'b0);
        offer_request(64'h5a5a_a5a5_0f0f_f0f0, 1'b0, 1'b1);
        offer_request(64'h0123_4567_89ab_cdef, 1'b0, 1'b0);
        offer_request('1, 1'b0, 1'b1);
        offer_request(64'hfedc_ba98_7654_3210, 1'b0, 1'b0);
        offer_request('1, 1'b1, 1'b1);
        offer_request(64'h8000_0000_0000_0001, 1'b0, 1'b0);
        offer_request(64'h7fff_ffff_ffff_fffe, 1'b1, 1'b0);
        wait_for_signatures();

        // Under the all-ones seed, empty sequences and sequences closed on a
        // word or word-free; a word-free close must ignore its nonzero word.
        load_seed('1);
        offer_request('1, 1'b1, 1'b1);
        offer_request('0, 1'b1, 1'b1);
        offer_request('1, 1'b0, 1'b0);
        offer_request('0, 1'b1, 1'b0);
        offer_request('1, 1'b0, 1'b0);
        offer_request('0, 1'b0, 1'b0);
        offer_request('1, 1'b1, 1'b1);
        wait_for_signatures();

        // Random phases. Each one starts with a long sequence around the
        // word limit (63 to 66 words), so that just below, exactly at and
        // past the limit are all reached, then sends random sequences. The
        // drain between phases also holds the sender until every result is
        // back.
        phase_seed[0] = {$urandom(), $urandom()};
        phase_seed[1] = '0;
        phase_seed[2] = '1;
        phase_seed[3] = {$urandom(), $urandom()};
        for (int p = 0; p < 4; p++) begin
            load_seed(phase_seed[p]);
            phase_start = sent_items;
            send_sequence(63 + p);
            while (sent_items - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    // Noise: an idle request with nothing around it.
                    offer_request(pick_word(), 1'b0, 1'b1);
                end else if (pick < 9) begin
                    send_sequence($urandom_range(62, 70));
                end else if (pick < 20) begin
                    send_sequence(0);
                end else begin
                    send_sequence($urandom_range(1, 8));
                end
            end
            wait_for_signatures();
        end

        if (fail_count == 0) begin
            $display("bitset_signature_hash: match");
        end else begin
            $display("bitset_signature_hash: mismatch");
        end
        $finish;
    end

endmodule
